>>> rtl/utf8c_pkg.sv
// ---------------------------------------------------------------------------
// utf8c_pkg
// types, constants and conversion functions of the utf-8 code point codec
// ---------------------------------------------------------------------------
package utf8c_pkg;

	// operation select
	typedef enum logic {
		FUNC_ENCODE = 1'b0,
		FUNC_DECODE = 1'b1
	} func_t;

	localparam int unsigned CP_W   = 21;
	localparam int unsigned WORD_W = 32;

	// encode length thresholds
	localparam logic [CP_W-1:0] CP_MAX_1B = 21'h00007f;
	localparam logic [CP_W-1:0] CP_MAX_2B = 21'h0007ff;
	localparam logic [CP_W-1:0] CP_MAX_3B = 21'h00ffff;

	// lead and continuation tags
	localparam logic [4:0] LEAD4_TAG = 5'b11110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [1:0] CONT_TAG  = 2'b10;

	// decode lead byte ranges
	localparam logic [7:0] LEAD4_MIN = 8'hf0;
	localparam logic [7:0] LEAD4_MAX = 8'hf4;
	localparam logic [7:0] LEAD3_MIN = 8'he0;
	localparam logic [7:0] LEAD2_MIN = 8'hc2;
	localparam logic [WORD_W-1:0] ASCII_LIMIT = 32'h00000080;

	function automatic logic [WORD_W-1:0] encode_cp(input logic [CP_W-1:0] cp);
		logic [WORD_W-1:0] w;
		if (cp > CP_MAX_3B) begin
			w = {CONT_TAG, cp[5:0], CONT_TAG, cp[11:6], CONT_TAG, cp[17:12],
				LEAD4_TAG, cp[20:18]};
		end else if (cp > CP_MAX_2B) begin
			w = {8'h00, CONT_TAG, cp[5:0], CONT_TAG, cp[11:6], LEAD3_TAG, cp[15:12]};
		end else if (cp > CP_MAX_1B) begin
			w = {16'h0000, CONT_TAG, cp[5:0], LEAD2_TAG, cp[10:6]};
		end else begin
			w = {11'h000, cp};
		end
		return w;
	endfunction

	// no validation: the lead byte alone sets the byte count
	function automatic logic [WORD_W-1:0] decode_word(input logic [WORD_W-1:0] w);
		logic [7:0]      lead;
		logic [5:0]      b1;
		logic [5:0]      b2;
		logic [5:0]      b3;
		logic [CP_W-1:0] v;
		logic [WORD_W-1:0] r;
		lead = w[7:0];
		b1   = w[13:8];
		b2   = w[21:16];
		b3   = w[29:24];
		if (lead >= LEAD4_MIN && lead <= LEAD4_MAX) begin
			v = {lead[2:0], b1, b2, b3};
		end else if (lead >= LEAD3_MIN) begin
			v = {5'h00, lead[3:0], b1, b2};
		end else if (lead >= LEAD2_MIN) begin
			v = {10'h000, lead[4:0], b1};
		end else begin
			v = {15'h0000, lead[5:0]};
		end
		if (w < ASCII_LIMIT) begin
			r = w;
		end else begin
			r = {11'h000, v};
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] codec(
		input logic              func,
		input logic [CP_W-1:0]   cp,
		input logic [WORD_W-1:0] w
	);
		logic [WORD_W-1:0] r;
		if (func == FUNC_DECODE) begin
			r = decode_word(w);
		end else begin
			r = encode_cp(cp);
		end
		return r;
	endfunction

endpackage

>>> rtl/utf8c_if.sv
// ---------------------------------------------------------------------------
// utf8c_if
// valid/ready channels of the utf-8 code point codec
// ---------------------------------------------------------------------------
interface utf8c_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [20:0] code_point;
	logic [31:0] packed_bytes;

	modport source (output valid, func, code_point, packed_bytes, input ready);
	modport sink   (input valid, func, code_point, packed_bytes, output ready);
endinterface

interface utf8c_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;

	modport source (output valid, result, input ready);
	modport sink   (input valid, result, output ready);
endinterface

>>> rtl/utf8_codepoint_codec.sv
// ---------------------------------------------------------------------------
// utf8_codepoint_codec
// utf-8 encoder and decoder, while rsp is not stalled one character per clock
// ---------------------------------------------------------------------------
// Each req transaction carries func and either a code point (func 0, encode)
// or a packed utf-8 word with the lead byte in bits 7:0 (func 1, decode);
// each one gives exactly one rsp transaction, in order. The block takes one
// transaction every cycle while rsp is not stalled: the request is registered
// in the input stage, converted by a few levels of compare and mux logic, and
// registered again in the result stage as the response, which stays on rsp
// until rsp.ready takes it; the next request can enter meanwhile. The
// two stages stall together only while a response waits and the stage in
// front of it is full; otherwise req.ready stays high. Encoding drops code
// point bits above 20 and picks 1 to 4 bytes from the 0x7f, 0x7ff and 0xffff
// thresholds; surrogates and values above 0x10ffff are encoded like any
// other. Decoding does no checking: a word below 0x80 passes as is, else the
// lead byte sets the count (0xf0-0xf4 four, 0xe0 and up three, 0xc2 and up
// two, anything else one) and continuation tags are not examined.
// ---------------------------------------------------------------------------
module utf8_codepoint_codec (
	input  logic              clk,
	input  logic              arst_n,
	utf8c_req_if.sink         req,
	utf8c_rsp_if.source       rsp
);
	import utf8c_pkg::*;

	// input stage
	logic              valid_s1;
	logic              func_s1;
	logic [CP_W-1:0]   cp_s1;
	logic [WORD_W-1:0] word_s1;

	// result stage
	logic              valid_s2;
	logic [WORD_W-1:0] result_s2;

	logic advance;
	logic load_s1;

	// result stage is free or is being emptied this cycle
	assign advance   = !valid_s2 || rsp.ready;
	// input stage can take a new item when empty or moving on
	assign req.ready = !valid_s1 || advance;
	assign load_s1   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (load_s1) begin
			func_s1 <= req.func;
			cp_s1   <= req.code_point;
			word_s1 <= req.packed_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// conversion sits between the two stages
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= codec(func_s1, cp_s1, word_s1);
		end
	end

	assign rsp.valid  = valid_s2;
	assign rsp.result = result_s2;

endmodule

>>> rtl/utf8c_checker.sv
// ---------------------------------------------------------------------------
// utf8c_checker
// port level checks of the utf-8 code point codec
// ---------------------------------------------------------------------------
module utf8c_checker (
	input  logic        clk,
	input  logic        arst_n,
	utf8c_req_if.sink   req,
	utf8c_rsp_if.source rsp
);
	import utf8c_pkg::*;

	// a held response keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result))
		else $error("response changed while stalled");

	// back-pressure only when a response is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid)
		else $error("request stalled with no pending response");

	// a fresh response must follow an accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(req.valid && req.ready, 2))
		else $error("response without matching request");

	// and carries the conversion of that request
	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> rsp.result == codec($past(req.func, 2),
			$past(req.code_point, 2), $past(req.packed_bytes, 2)))
		else $error("response value mismatch");

endmodule

bind utf8_codepoint_codec utf8c_checker u_utf8c_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
